/* sv/qrs_pkg.sv */
package qrs_pkg;

  localparam int unsigned OUT_WIDTH = 25;

  typedef enum logic [1:0] {
    CNT_NONE   = 2'd0,
    CNT_SINGLE = 2'd1,
    CNT_DOUBLE = 2'd2
  } count_e;

  // sideband that travels alongside each transaction
  typedef struct packed {
    logic   vld;
    logic   fault;
    logic   neg;
    count_e cnt;
  } tag_t;

endpackage

/* sv/quadratic_root_solver.sv */
// Pipeline: product and discriminant registers, the square root cell chain (one digit per
//   cell), the magnitude register, the divider cell chain (one bit per cell), the output register.
// Throughput: one transaction per cycle; busy stays low, so start is never held off.
// Reset clears the valid pipeline only; result_valid_o is low out of reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [COEF_WIDTH-1:0]         coef_square_i,
  input  logic [COEF_WIDTH-1:0]         coef_linear_i,
  input  logic [COEF_WIDTH-1:0]         coef_const_i,
  output logic                          result_valid_o,
  output logic [qrs_pkg::OUT_WIDTH-1:0] root_plus_o,
  output logic [qrs_pkg::OUT_WIDTH-1:0] root_minus_o,
  output logic [1:0]                    real_root_count_o,
  output logic                          divide_fault_o
);
  import qrs_pkg::*;

  localparam int CW   = COEF_WIDTH;
  localparam int DW   = 2*CW + 2;            // discriminant width, signed
  localparam int RADW = DW + 2*FRAC_BITS;    // radicand bits (even)
  localparam int NSQ  = RADW / 2;            // sqrt cells
  localparam int SW   = NSQ;                 // root width
  localparam int RW   = SW + 2;              // remainder width
  localparam int NW   = SW + 1 > CW + FRAC_BITS + 1 ? SW + 1 : CW + FRAC_BITS + 1;
  localparam int MW   = CW + 1;              // |2a|
  localparam int NDV  = NW;                  // divider cells
  localparam int XW   = NW + 1;              // signed quotient width
  localparam int OUTW = int'(OUT_WIDTH);
  localparam int LAT  = 2 + NSQ + 1 + NDV + 1;

  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  // stage 1: products
  logic signed [CW-1:0] a_s, b_s, c_s;
  assign a_s = signed'(coef_square_i[CW-1:0]);
  assign b_s = signed'(coef_linear_i[CW-1:0]);
  assign c_s = signed'(coef_const_i[CW-1:0]);

  logic signed [2*CW-1:0] bb_q, ac_q;
  logic signed [CW-1:0]   a1_q, b1_q;
  always_ff @(posedge clk_i) begin
    bb_q <= b_s * b_s;
    ac_q <= a_s * c_s;
    a1_q <= a_s;
    b1_q <= b_s;
  end

  // stage 2: discriminant and tag
  logic signed [DW-1:0] disc;
  assign disc = DW'(bb_q) - (DW'(ac_q) <<< 2);

  logic [DW-1:0]        d2_q;
  logic signed [CW-1:0] a2_q, b2_q;
  tag_t                 t2_q;
  logic                 v1_q;
  tag_t                 t2_d;

  always_comb begin
    t2_d.vld   = v1_q;
    t2_d.fault = (a1_q == '0);
    t2_d.neg   = disc[DW-1];
    priority if (t2_d.fault || t2_d.neg) t2_d.cnt = CNT_NONE;
    else if (disc == '0)                 t2_d.cnt = CNT_SINGLE;
    else                                 t2_d.cnt = CNT_DOUBLE;
  end

  always_ff @(posedge clk_i) begin
    d2_q <= disc[DW-1] ? '0 : disc;
    a2_q <= a1_q;
    b2_q <= b1_q;
  end

  // square root cell chain with coefficient side pipeline
  logic [RW-1:0]        sq_rem  [NSQ+1];
  logic [SW-1:0]        sq_root [NSQ+1];
  logic [RADW-1:0]      sq_rad  [NSQ+1];
  logic signed [CW-1:0] sa_q    [NSQ+1];
  logic signed [CW-1:0] sb_q    [NSQ+1];
  tag_t                 st_q    [NSQ+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {d2_q, {(2*FRAC_BITS){1'b0}}};
  always_comb begin
    sa_q[0] = a2_q;
    sb_q[0] = b2_q;
    st_q[0] = t2_q;
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    qrs_sqrt_cell #(.RW(RW), .SW(SW), .DW(RADW)) u_cell (
      .clk_i (clk_i),
      .rem_i (sq_rem[i]),  .root_i (sq_root[i]), .rad_i (sq_rad[i]),
      .rem_o (sq_rem[i+1]), .root_o (sq_root[i+1]), .rad_o (sq_rad[i+1])
    );
    always_ff @(posedge clk_i) begin
      sa_q[i+1] <= sa_q[i];
      sb_q[i+1] <= sb_q[i];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) st_q[i+1] <= '0;
      else         st_q[i+1] <= st_q[i];
    end
  end

  // stage: signed numerators to magnitudes
  localparam int SNW = NW + 1;
  logic signed [SNW-1:0] nb, np, nm;
  assign nb = SNW'(-(SNW'(sb_q[NSQ]))) <<< FRAC_BITS;
  assign np = nb + SNW'(sq_root[NSQ]);
  assign nm = nb - SNW'(sq_root[NSQ]);

  logic [NW-1:0] mp_q, mm_q;
  logic [MW-1:0] den_q;
  logic          sp_q, sm_q;
  tag_t          tn_q;
  always_ff @(posedge clk_i) begin
    mp_q  <= np[SNW-1] ? NW'(-np) : NW'(np);
    mm_q  <= nm[SNW-1] ? NW'(-nm) : NW'(nm);
    den_q <= sa_q[NSQ][CW-1] ? MW'(-(MW'(sa_q[NSQ])) <<< 1) : MW'(MW'(sa_q[NSQ]) <<< 1);
    // quotient sign: numerator sign xor divisor sign
    sp_q  <= np[SNW-1] ^ sa_q[NSQ][CW-1];
    sm_q  <= nm[SNW-1] ^ sa_q[NSQ][CW-1];
  end

  // divider cell chain
  logic [NW-1:0] dv_np [NDV+1];
  logic [NW-1:0] dv_nm [NDV+1];
  logic [MW:0]   dv_rp [NDV+1];
  logic [MW:0]   dv_rm [NDV+1];
  logic [MW-1:0] dv_dn [NDV+1];
  logic          ds_p  [NDV+1];
  logic          ds_m  [NDV+1];
  tag_t          dt_q  [NDV+1];

  assign dv_np[0] = mp_q;
  assign dv_nm[0] = mm_q;
  assign dv_rp[0] = '0;
  assign dv_rm[0] = '0;
  assign dv_dn[0] = den_q;
  always_comb begin
    ds_p[0] = sp_q;
    ds_m[0] = sm_q;
    dt_q[0] = tn_q;
  end

  for (genvar j = 0; j < NDV; j++) begin : g_dv
    qrs_div_cell #(.NW(NW), .MW(MW)) u_cell (
      .clk_i   (clk_i),
      .num_p_i (dv_np[j]),   .num_m_i (dv_nm[j]),
      .rem_p_i (dv_rp[j]),   .rem_m_i (dv_rm[j]),   .den_i (dv_dn[j]),
      .num_p_o (dv_np[j+1]), .num_m_o (dv_nm[j+1]),
      .rem_p_o (dv_rp[j+1]), .rem_m_o (dv_rm[j+1]), .den_o (dv_dn[j+1])
    );
    always_ff @(posedge clk_i) begin
      ds_p[j+1] <= ds_p[j];
      ds_m[j+1] <= ds_m[j];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dt_q[j+1] <= '0;
      else         dt_q[j+1] <= dt_q[j];
    end
  end

  // final: sign, saturate, output register
  localparam logic signed [XW-1:0] OMAX = XW'((64'sd1 <<< (OUTW-1)) - 1);
  localparam logic signed [XW-1:0] OMIN = -OMAX - XW'(1);

  function automatic logic [OUTW-1:0] sat(input logic [NW-1:0] mag, input logic s);
    logic signed [XW-1:0] v;
    v = s ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    if (v > OMAX)      sat = OUTW'(OMAX);
    else if (v < OMIN) sat = OUTW'(OMIN);
    else               sat = OUTW'(v);
  endfunction

  tag_t          tf;
  logic [OUTW-1:0] rp_d, rm_d;
  logic [OUTW-1:0] rp_q, rm_q;
  logic [1:0]      cnt_q;
  logic            flt_q, vo_q;
  always_comb begin
    tf   = dt_q[NDV];
    rp_d = (tf.fault || tf.neg) ? '0 : sat(dv_np[NDV], ds_p[NDV]);
    rm_d = (tf.fault || tf.neg) ? '0 : sat(dv_nm[NDV], ds_m[NDV]);
  end

  always_ff @(posedge clk_i) begin
    rp_q  <= rp_d;
    rm_q  <= rm_d;
    cnt_q <= tf.cnt;
    flt_q <= tf.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      t2_q <= '0;
      tn_q <= '0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= acc;
      t2_q <= t2_d;
      tn_q <= st_q[NSQ];
      vo_q <= tf.vld;
    end
  end

  assign result_valid_o    = vo_q;
  assign root_plus_o       = rp_q;
  assign root_minus_o      = rm_q;
  assign real_root_count_o = cnt_q;
  assign divide_fault_o    = flt_q;

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(acc, LAT))
    else $error("result without matching transaction");
  a_flt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && divide_fault_o |-> real_root_count_o == CNT_NONE && root_plus_o == '0)
    else $error("fault with roots");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> real_root_count_o != 2'd3)
    else $error("bad root count");
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && real_root_count_o == CNT_SINGLE |-> root_plus_o == root_minus_o)
    else $error("single root differs");
endmodule

/* sv/qrs_sqrt_cell.sv */
// One digit of the restoring square root: one radicand bit pair per cell.
module qrs_sqrt_cell #(
  parameter int RW = 34,
  parameter int SW = 42,
  parameter int DW = 66
) (
  input  logic          clk_i,
  input  logic [RW-1:0] rem_i,
  input  logic [SW-1:0] root_i,
  input  logic [DW-1:0] rad_i,
  output logic [RW-1:0] rem_o,
  output logic [SW-1:0] root_o,
  output logic [DW-1:0] rad_o
);
  logic [RW-1:0] rem_sh, trial;
  logic          take;
  logic [RW-1:0] rem_q;
  logic [SW-1:0] root_q;
  logic [DW-1:0] rad_q;

  always_comb begin
    rem_sh = {rem_i[RW-3:0], rad_i[DW-1 -: 2]};
    trial  = {root_i[RW-3:0], 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= take ? rem_sh - trial : rem_sh;
    root_q <= {root_i[SW-2:0], take};
    rad_q  <= {rad_i[DW-3:0], 2'b00};
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
endmodule

/* sv/qrs_div_cell.sv */
// One quotient bit of a restoring divide on magnitudes, for both roots at once.
module qrs_div_cell #(
  parameter int NW = 42,
  parameter int MW = 18
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_p_i,
  input  logic [NW-1:0] num_m_i,
  input  logic [MW:0]   rem_p_i,
  input  logic [MW:0]   rem_m_i,
  input  logic [MW-1:0] den_i,
  output logic [NW-1:0] num_p_o,
  output logic [NW-1:0] num_m_o,
  output logic [MW:0]   rem_p_o,
  output logic [MW:0]   rem_m_o,
  output logic [MW-1:0] den_o
);
  logic [MW:0] sp, sm;
  logic        tp, tm;

  always_comb begin
    sp = {rem_p_i[MW-1:0], num_p_i[NW-1]};
    sm = {rem_m_i[MW-1:0], num_m_i[NW-1]};
    tp = sp >= {1'b0, den_i};
    tm = sm >= {1'b0, den_i};
  end

  logic [NW-1:0] np_q, nm_q;
  logic [MW:0]   rp_q, rm_q;
  logic [MW-1:0] den_q;

  // quotient bits shift into the low end as numerator bits leave the top
  always_ff @(posedge clk_i) begin
    np_q  <= {num_p_i[NW-2:0], tp};
    nm_q  <= {num_m_i[NW-2:0], tm};
    rp_q  <= tp ? sp - {1'b0, den_i} : sp;
    rm_q  <= tm ? sm - {1'b0, den_i} : sm;
    den_q <= den_i;
  end

  assign num_p_o = np_q;
  assign num_m_o = nm_q;
  assign rem_p_o = rp_q;
  assign rem_m_o = rm_q;
  assign den_o   = den_q;
endmodule
